@@ rtl/set_assoc_cache_tag_controller_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag controller
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define SACTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sactc_pkg.sv @@
// ---------------------------------------------------------------------------
// sactc_pkg
// Shared types, constants and helpers of the cache tag controller.
// ---------------------------------------------------------------------------
package sactc_pkg;

    // default sizing
    localparam int MAX_SETS_DEF   = 16;
    localparam int MAX_WAYS_DEF   = 4;
    localparam int ADDR_WIDTH_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_BITS  = 3'd0,
        CFG_OFFSET_BITS = 3'd1,
        CFG_WAYS        = 3'd2,
        CFG_REPLACE     = 3'd3,
        CFG_WRITE       = 3'd4
    } t_cfg_idx;

    localparam logic REPL_LRU       = 1'b0;
    localparam logic REPL_RANDOM    = 1'b1;
    localparam logic WMODE_COPYBACK = 1'b0;
    localparam logic WMODE_THRU     = 1'b1;

    // block offset limits
    localparam logic [2:0] OB_MIN = 3'd2;
    localparam logic [2:0] OB_MAX = 3'd5;

    // way count, wide enough for the largest associativity
    localparam int WCNT_W = 5;

    // per-way entry layout inside a set row: {tag, valid, dirty, age}
    localparam int AGE_LSB   = 0;
    localparam int AGE_W     = 2;
    localparam int DIRTY_BIT = 2;
    localparam int VALID_BIT = 3;
    localparam int TAG_LSB   = 4;
    localparam logic [AGE_W-1:0] AGE_MAX = 2'd3;

    typedef struct packed {
        logic [2:0] index_bits;
        logic [2:0] offset_bits;
        logic [2:0] ways_in_use;
        logic       replace_mode;
        logic       write_mode;
    } t_cfg;

    // result status bits, lookup to top
    typedef struct packed {
        logic bypass;
        logic hit;
        logic writeback_needed;
        logic fill_needed;
        logic word_write_through;
    } t_flags;

    // offset bits clamped into the legal block sizes
    function automatic logic [2:0] eff_offset_bits(logic [2:0] ob);
        logic [2:0] r;
        r = ob;
        if (ob < OB_MIN) r = OB_MIN;
        if (ob > OB_MAX) r = OB_MAX;
        return r;
    endfunction

    // index bits clamped so the set count fits the set store
    function automatic logic [2:0] eff_index_bits(logic [2:0] ib, int ib_max);
        logic [2:0] r;
        r = ib;
        if (int'(ib) > ib_max) r = 3'(ib_max);
        return r;
    endfunction

    // random way modulo the way count (random way is below 4: three subtracts)
    function automatic logic [1:0] rnd_mod(logic [1:0] rnd, logic [WCNT_W-1:0] ways);
        logic [WCNT_W-1:0] v;
        v = WCNT_W'(rnd);
        for (int k = 0; k < 3; k++) begin
            if (ways != '0 && v >= ways) v = v - ways;
        end
        return v[1:0];
    endfunction

endpackage

@@ rtl/sactc_req_if.sv @@
// ---------------------------------------------------------------------------
// sactc_req_if
// Access request channel: valid/ready handshake with the access word.
// ---------------------------------------------------------------------------
interface sactc_req_if #(
    parameter int ADDR_WIDTH = sactc_pkg::ADDR_WIDTH_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [ADDR_WIDTH-1:0] byte_addr;
    logic [1:0]            random_way;

    modport source (output valid, func, byte_addr, random_way, input ready);
    modport sink   (input valid, func, byte_addr, random_way, output ready);
endinterface

@@ rtl/sactc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// sactc_rsp_if
// Lookup result channel: valid/ready handshake with the result word.
// ---------------------------------------------------------------------------
interface sactc_rsp_if #(
    parameter int ADDR_WIDTH = sactc_pkg::ADDR_WIDTH_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  bypass;
    logic                  hit;
    logic [1:0]            way_used;
    logic                  writeback_needed;
    logic [ADDR_WIDTH-1:0] writeback_addr;
    logic                  fill_needed;
    logic                  word_write_through;

    modport source (output valid, bypass, hit, way_used, writeback_needed,
                    writeback_addr, fill_needed, word_write_through, input ready);
    modport sink   (input valid, bypass, hit, way_used, writeback_needed,
                    writeback_addr, fill_needed, word_write_through, output ready);
endinterface

@@ rtl/sactc_ram.sv @@
// ---------------------------------------------------------------------------
// sactc_ram
// Generic RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sactc_lookup.sv @@
// ---------------------------------------------------------------------------
// sactc_lookup
// Tag match, victim choice and set row update for one access.
// ---------------------------------------------------------------------------
module sactc_lookup #(
    parameter int MAX_SETS   = sactc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sactc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sactc_pkg::ADDR_WIDTH_DEF,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int TAG_W   = ADDR_WIDTH - int'(sactc_pkg::OB_MIN),
    localparam int ENTRY_W = TAG_W + sactc_pkg::TAG_LSB
) (
    input  sactc_pkg::t_cfg                    i_cfg,
    input  logic                               i_func,
    input  logic [1:0]                         i_rnd,
    input  logic [SET_W-1:0]                   i_set,
    input  logic [TAG_W-1:0]                   i_tag,
    input  logic [MAX_WAYS-1:0][ENTRY_W-1:0]   i_row,
    output sactc_pkg::t_flags                  o_flags,
    output logic [WAY_W-1:0]                   o_way,
    output logic [ADDR_WIDTH-1:0]              o_wb_addr,
    output logic [MAX_WAYS-1:0][ENTRY_W-1:0]   o_row
);

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int AL     = sactc_pkg::AGE_LSB;
    localparam int AH     = sactc_pkg::AGE_LSB + sactc_pkg::AGE_W - 1;

    logic [sactc_pkg::WCNT_W-1:0] ways_eff;
    logic [2:0]                   ob;
    logic [2:0]                   ib;
    logic [3:0]                   shamt;
    logic [MAX_WAYS-1:0]          match;
    logic [WAY_W-1:0]             hit_way;
    logic [WAY_W-1:0]             lru_way;
    logic [sactc_pkg::AGE_W-1:0]  best_age;
    logic [WAY_W-1:0]             victim;
    logic [WAY_W-1:0]             way;
    logic                         hit;
    logic                         bypass;
    logic                         wr_back;
    logic                         wb_needed;
    logic [ENTRY_W-1:0]           ent;

    // effective geometry
    always_comb begin
        if ({2'b00, i_cfg.ways_in_use} > sactc_pkg::WCNT_W'(MAX_WAYS)) begin
            ways_eff = sactc_pkg::WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = {2'b00, i_cfg.ways_in_use};
        end
        ob     = sactc_pkg::eff_offset_bits(i_cfg.offset_bits);
        ib     = sactc_pkg::eff_index_bits(i_cfg.index_bits, IB_MAX);
        shamt  = {1'b0, ob} + {1'b0, ib};
        bypass = (i_cfg.ways_in_use == '0);
    end

    // tag compare, lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            match[w] = (sactc_pkg::WCNT_W'(w) < ways_eff) && i_row[w][sactc_pkg::VALID_BIT]
                       && (i_row[w][ENTRY_W-1:sactc_pkg::TAG_LSB] == i_tag);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) hit_way = WAY_W'(w);
        end
        hit = |match;
    end

    // victim: oldest way (ties to lowest) or the offered random way
    always_comb begin
        best_age = '0;
        lru_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((sactc_pkg::WCNT_W'(w) < ways_eff) && (i_row[w][AH:AL] > best_age)) begin
                best_age = i_row[w][AH:AL];
                lru_way  = WAY_W'(w);
            end
        end
        if (i_cfg.replace_mode == sactc_pkg::REPL_RANDOM) begin
            victim = WAY_W'(sactc_pkg::rnd_mod(i_rnd, ways_eff));
        end else begin
            victim = lru_way;
        end
        way = hit ? hit_way : victim;
    end

    // dirty victim writeback address: stored tag and set, zero offset; none on bypass
    always_comb begin
        wb_needed = !bypass && !hit && i_row[way][sactc_pkg::VALID_BIT]
                    && i_row[way][sactc_pkg::DIRTY_BIT];
        if (wb_needed) begin
            o_wb_addr = (ADDR_WIDTH'(i_row[way][ENTRY_W-1:sactc_pkg::TAG_LSB]) << shamt)
                      | (ADDR_WIDTH'(i_set) << ob);
        end else begin
            o_wb_addr = '0;
        end
    end

    // set row update: refill on miss, dirty marking, aging
    always_comb begin
        wr_back = i_func && (i_cfg.write_mode == sactc_pkg::WMODE_COPYBACK);
        for (int w = 0; w < MAX_WAYS; w++) begin
            ent = i_row[w];
            if (WAY_W'(w) == way) begin
                ent[AH:AL] = '0;
                if (!hit) begin
                    ent[ENTRY_W-1:sactc_pkg::TAG_LSB] = i_tag;
                    ent[sactc_pkg::VALID_BIT]         = 1'b1;
                    ent[sactc_pkg::DIRTY_BIT]         = wr_back;
                end else if (wr_back) begin
                    ent[sactc_pkg::DIRTY_BIT] = 1'b1;
                end
            end else if ((sactc_pkg::WCNT_W'(w) < ways_eff) && (ent[AH:AL] < sactc_pkg::AGE_MAX)) begin
                ent[AH:AL] = ent[AH:AL] + 1'b1;
            end
            o_row[w] = ent;
        end
    end

    // result status
    always_comb begin
        if (bypass) begin
            o_flags                    = '0;
            o_flags.bypass             = 1'b1;
            o_flags.word_write_through = i_func;
            o_way                      = '0;
        end else begin
            o_flags.bypass             = 1'b0;
            o_flags.hit                = hit;
            o_flags.writeback_needed   = wb_needed;
            o_flags.fill_needed        = !hit;
            o_flags.word_write_through = i_func
                                         && (i_cfg.write_mode == sactc_pkg::WMODE_THRU);
            o_way                      = way;
        end
    end

endmodule

@@ rtl/set_assoc_cache_tag_controller_top.sv @@
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_controller_top: set-associative cache tag controller
// Read-modify-write of the set row in the tag RAM: read at request accept, written
// when the result register loads; one access in flight, held while the result stalls.
// Reset: config and control registers to defaults, row-valid flops clear so every set reads empty.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_controller_top #(
    parameter int MAX_SETS   = sactc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sactc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sactc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sactc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sactc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sactc_req_if.sink                        i_req,
    sactc_rsp_if.source                      o_rsp
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W   = ADDR_WIDTH - int'(sactc_pkg::OB_MIN);
    localparam int ENTRY_W = TAG_W + sactc_pkg::TAG_LSB;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    localparam int IB_MAX  = $clog2(MAX_SETS + 1) - 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    sactc_pkg::t_cfg         r_cfg;
    logic [MAX_SETS-1:0]     r_row_valid;

    // access captured at accept
    logic                    r_func;
    logic [1:0]              r_rnd;
    logic [SET_W-1:0]        r_set;
    logic [TAG_W-1:0]        r_tag;
    logic                    r_rv;

    // result register
    sactc_pkg::t_flags       r_flags;
    logic [WAY_W-1:0]        r_way;
    logic [ADDR_WIDTH-1:0]   r_wb_addr;

    logic                    accept;
    logic                    done;
    logic [2:0]              ob_in;
    logic [2:0]              ib_in;
    logic [ADDR_WIDTH-1:0]   addr_sh;
    logic [SET_W-1:0]        acc_set;
    logic [TAG_W-1:0]        acc_tag;
    logic [ROW_W-1:0]        ram_rdata;
    logic [MAX_WAYS-1:0][ENTRY_W-1:0] row_rd;
    logic [MAX_WAYS-1:0][ENTRY_W-1:0] row_wr;
    logic                    ram_we;
    sactc_pkg::t_flags       lk_flags;
    logic [WAY_W-1:0]        lk_way;
    logic [ADDR_WIDTH-1:0]   lk_wb_addr;

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign done        = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign ram_we      = done && !lk_flags.bypass;

    // address split at accept: set selects the RAM row
    always_comb begin
        ob_in   = sactc_pkg::eff_offset_bits(r_cfg.offset_bits);
        ib_in   = sactc_pkg::eff_index_bits(r_cfg.index_bits, IB_MAX);
        addr_sh = i_req.byte_addr >> ob_in;
        acc_set = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << ib_in);
        acc_tag = TAG_W'(i_req.byte_addr >> ({1'b0, ob_in} + {1'b0, ib_in}));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_bits   <= 3'd0;
            r_cfg.offset_bits  <= sactc_pkg::OB_MIN;
            r_cfg.ways_in_use  <= 3'd1;
            r_cfg.replace_mode <= sactc_pkg::REPL_LRU;
            r_cfg.write_mode   <= sactc_pkg::WMODE_COPYBACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sactc_pkg::CFG_INDEX_BITS:  r_cfg.index_bits   <= i_cfg_data;
                sactc_pkg::CFG_OFFSET_BITS: r_cfg.offset_bits  <= i_cfg_data;
                sactc_pkg::CFG_WAYS:        r_cfg.ways_in_use  <= i_cfg_data;
                sactc_pkg::CFG_REPLACE:     r_cfg.replace_mode <= i_cfg_data[0];
                sactc_pkg::CFG_WRITE:       r_cfg.write_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control: one access in flight, result register drains independently
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_LOOK;
            S_LOOK:  if (done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (done) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_row_valid[r_set] <= 1'b1;
            end
        end
    end

    // access capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req.func;
            r_rnd  <= i_req.random_way;
            r_set  <= acc_set;
            r_tag  <= acc_tag;
            r_rv   <= r_row_valid[acc_set];
        end
    end

    // set rows: tag, valid, dirty and age of every way
    sactc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (row_wr),
        .i_re    (accept),
        .i_raddr (acc_set),
        .o_rdata (ram_rdata)
    );

    // a row never written since reset reads as all ways empty
    assign row_rd = r_rv ? ram_rdata : '0;

    sactc_lookup #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_lookup (
        .i_cfg     (r_cfg),
        .i_func    (r_func),
        .i_rnd     (r_rnd),
        .i_set     (r_set),
        .i_tag     (r_tag),
        .i_row     (row_rd),
        .o_flags   (lk_flags),
        .o_way     (lk_way),
        .o_wb_addr (lk_wb_addr),
        .o_row     (row_wr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_flags   <= lk_flags;
            r_way     <= lk_way;
            r_wb_addr <= lk_wb_addr;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.bypass             = r_flags.bypass;
    assign o_rsp.hit                = r_flags.hit;
    assign o_rsp.way_used           = 2'(r_way);
    assign o_rsp.writeback_needed   = r_flags.writeback_needed;
    assign o_rsp.writeback_addr     = r_wb_addr;
    assign o_rsp.fill_needed        = r_flags.fill_needed;
    assign o_rsp.word_write_through = r_flags.word_write_through;

endmodule

@@ rtl/sactc_checker.sv @@
// ---------------------------------------------------------------------------
// sactc_checker
// Port-level checks of the tag controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_top_defines.svh"

module sactc_checker #(
    parameter int ADDR_WIDTH = sactc_pkg::ADDR_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_req_func,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [1:0]            i_rsp_way_used,
    input logic [ADDR_WIDTH-1:0] i_rsp_wb_addr,
    input logic                  i_rsp_wt
);

    // a stalled result word holds
    `SACTC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_wb_addr) && $stable(i_rsp_way_used), "result word changed while stalled")

    // one access in flight: no accept right after an accept
    `SACTC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request accepted during lookup")

    // a fresh result traces back to an accept, through S_LOOK and the result register
    `SACTC_ASSERT_IMPLY(a_rsp_from_req, i_clk, i_rst_n, $rose(i_rsp_valid), $past(i_req_valid && i_req_ready, 2), "result without a request")

    // a read never writes a word through
    `SACTC_ASSERT_IMPLY(a_read_no_wt, i_clk, i_rst_n, $rose(i_rsp_valid) && !$past(i_req_func, 2), !i_rsp_wt, "write-through on a read")

endmodule

bind set_assoc_cache_tag_controller_top sactc_checker #(
    .ADDR_WIDTH (ADDR_WIDTH)
) u_sactc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_func     (i_req.func),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_way_used (o_rsp.way_used),
    .i_rsp_wb_addr  (o_rsp.writeback_addr),
    .i_rsp_wt       (o_rsp.word_write_through)
);
